@@ design/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the shape fill rasterizer: widths, action
// codes, the classified command that the front hands to the back, and the
// sequencer states.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // frame store geometry
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;

   localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

   // field widths
   localparam int ACTION_W   = 2;
   localparam int COORD_IN_W = 8;
   localparam int LEN_W      = 7;
   localparam int CANVAS_W   = 7;
   localparam int PIXEL_W    = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // internal signed coordinate: holds row +/- length and every canvas index
   localparam int COORD_BASE = (ROW_CNT_W > COL_CNT_W) ? ROW_CNT_W : COL_CNT_W;
   localparam int COORD_W    = ((COORD_BASE > COORD_IN_W + 1) ? COORD_BASE
                                                              : COORD_IN_W + 1) + 1;

   // squared distances; inside the bounding box |offset| <= radius
   localparam int SQ_W   = 2 * LEN_W;
   localparam int DIST_W = SQ_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [PIXEL_W-1:0] PIXEL_ON  = 8'd255;
   localparam logic [PIXEL_W-1:0] PIXEL_OFF = 8'd0;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_RECT   = 2'd1,
      ACT_CIRCLE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic {
      REG_ROWS = 1'b0,
      REG_COLS = 1'b1
   } csr_reg_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      action_type      op;
      coord_type       row_ctr;
      coord_type       col_ctr;
      coord_type       row_lo;
      coord_type       row_hi;
      coord_type       col_lo;
      coord_type       col_hi;
      logic [SQ_W-1:0] r2;
   } cmd_type;

   typedef struct packed {
      logic [ROW_CNT_W-1:0] eff_rows;
      logic [COL_CNT_W-1:0] eff_cols;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ROW,
      ST_SCAN,
      ST_MERGE,
      ST_READ
   } back_state_type;

endpackage

@@ design/sfr_csr.sv @@
// ----------------------------------------------------------------------------
// sfr_csr
// Canvas size registers behind the APB-style port, with the sizes clamped
// to the frame store for use by the back end.
// ----------------------------------------------------------------------------
module sfr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [sfr_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output sfr_pkg::cfg_type                 cfg
);
   import sfr_pkg::*;

   logic [CANVAS_W-1:0] canvas_rows_ff, canvas_rows_in;
   logic [CANVAS_W-1:0] canvas_cols_ff, canvas_cols_in;
   logic                wr_en;
   csr_reg_type         reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = csr_reg_type'(paddr[2]);

   always_comb begin
      canvas_rows_in = canvas_rows_ff;
      canvas_cols_in = canvas_cols_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_ROWS: canvas_rows_in = pwdata[CANVAS_W-1:0];
            REG_COLS: canvas_cols_in = pwdata[CANVAS_W-1:0];
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_rows_ff <= CANVAS_W'(64);
         canvas_cols_ff <= CANVAS_W'(64);
      end else begin
         canvas_rows_ff <= canvas_rows_in;
         canvas_cols_ff <= canvas_cols_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_ROWS: prdata = CSR_DATA_W'(canvas_rows_ff);
         REG_COLS: prdata = CSR_DATA_W'(canvas_cols_ff);
         default:  prdata = '0;
      endcase
   end

   // clamp to the store size
   always_comb begin
      if (int'(canvas_rows_ff) > MAX_ROWS) begin
         cfg.eff_rows = ROW_CNT_W'(MAX_ROWS);
      end else begin
         cfg.eff_rows = ROW_CNT_W'(canvas_rows_ff);
      end
      if (int'(canvas_cols_ff) > MAX_COLS) begin
         cfg.eff_cols = COL_CNT_W'(MAX_COLS);
      end else begin
         cfg.eff_cols = COL_CNT_W'(canvas_cols_ff);
      end
   end

endmodule

@@ design/sfr_front.sv @@
// ----------------------------------------------------------------------------
// sfr_front
// Takes commands, works out the shape's bounding rows and columns and the
// squared radius, and queues the classified command for the back end.
// ----------------------------------------------------------------------------
module sfr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sfr_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [sfr_pkg::COORD_IN_W-1:0] req_row,
   input  logic signed [sfr_pkg::COORD_IN_W-1:0] req_col,
   input  logic [sfr_pkg::LEN_W-1:0]           req_height,
   input  logic [sfr_pkg::LEN_W-1:0]           req_width,
   input  logic [sfr_pkg::LEN_W-1:0]           req_radius,
   output logic                                cmd_valid,
   input  logic                                cmd_pop,
   output sfr_pkg::cmd_type                    cmd
);
   import sfr_pkg::*;

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   cmd_type             cls;
   coord_type           row_c, col_c;

   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = start & ~busy;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   // classify
   always_comb begin
      row_c       = coord_type'(req_row);
      col_c       = coord_type'(req_col);
      cls.op      = action_type'(req_action);
      cls.row_ctr = row_c;
      cls.col_ctr = col_c;
      cls.row_lo  = row_c;
      cls.row_hi  = row_c;
      cls.col_lo  = col_c;
      cls.col_hi  = col_c;
      cls.r2      = {{LEN_W{1'b0}}, req_radius} * {{LEN_W{1'b0}}, req_radius};
      unique case (cls.op)
         ACT_RECT: begin
            cls.row_hi = row_c + coord_type'(req_height);
            cls.col_hi = col_c + coord_type'(req_width);
         end
         ACT_CIRCLE: begin
            cls.row_lo = row_c - coord_type'(req_radius);
            cls.row_hi = row_c + coord_type'(req_radius);
            cls.col_lo = col_c - coord_type'(req_radius);
            cls.col_hi = col_c + coord_type'(req_radius);
         end
         default: ;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> count_ff != '0)
      else $error("pop from empty queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !cmd_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on push");
`endif

endmodule

@@ design/sfr_back.sv @@
// ----------------------------------------------------------------------------
// sfr_back
// Carries out one command at a time on the frame store, kept as one memory
// row per canvas row with a valid bit per row (an invalid row reads as off).
// Fills go row by row: read, merge the row mask, write back.
// ----------------------------------------------------------------------------
module sfr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  sfr_pkg::cfg_type            cfg,
   input  logic                        cmd_valid,
   output logic                        cmd_pop,
   input  sfr_pkg::cmd_type            cmd,
   output logic                        rsp_strobe,
   output logic [sfr_pkg::PIXEL_W-1:0] rsp_pixel_value
);
   import sfr_pkg::*;

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [ROW_CNT_W-1:0]  i_ff, i_in;
   logic [COL_CNT_W-1:0]  j_ff, j_in;
   logic [MAX_COLS-1:0]   mask_ff, mask_in;
   logic [SQ_W-1:0]       di2_ff, di2_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [PIXEL_W-1:0]    rsp_pixel_ff, rsp_pixel_in;

   // frame store
   logic [MAX_COLS-1:0]   frame_mem [MAX_ROWS];
   logic [MAX_ROWS-1:0]   row_valid_ff;
   logic [MAX_COLS-1:0]   rd_data_ff;
   logic                  rd_valid_ff;
   logic                  mem_rd_en;
   logic [ROW_AW-1:0]     mem_rd_addr;
   logic                  mem_wr_en;
   logic [MAX_COLS-1:0]   mem_wr_data;
   logic                  clear_all;

   // conditions
   coord_type             i_c, j_c, rows_c, cols_c, di, dj;
   logic [LEN_W-1:0]      di_mag, dj_mag;
   logic [SQ_W-1:0]       dj2;
   logic [DIST_W-1:0]     dist_sum;
   logic                  rows_done, row_hit, scan_last, in_canvas, pix_hit;
   logic [MAX_COLS-1:0]   rect_mask, row_mask;
   logic [ROW_AW-1:0]     row_idx;

   assign row_idx = i_ff[ROW_AW-1:0];

   always_comb begin
      i_c    = coord_type'(i_ff);
      j_c    = coord_type'(j_ff);
      rows_c = coord_type'(cfg.eff_rows);
      cols_c = coord_type'(cfg.eff_cols);
      rows_done = (i_ff >= cfg.eff_rows) || (cfg.eff_cols == '0);
      row_hit   = (i_c >= cmd_ff.row_lo) && (i_c < cmd_ff.row_hi);
      scan_last = (j_ff == cfg.eff_cols - 1'b1);
      in_canvas = (cmd_ff.row_ctr >= 0) && (cmd_ff.row_ctr < rows_c) &&
                  (cmd_ff.col_ctr >= 0) && (cmd_ff.col_ctr < cols_c);
      di     = i_c - cmd_ff.row_ctr;
      dj     = j_c - cmd_ff.col_ctr;
      di_mag = (di < 0) ? LEN_W'(-di) : LEN_W'(di);
      dj_mag = (dj < 0) ? LEN_W'(-dj) : LEN_W'(dj);
      dj2    = {{LEN_W{1'b0}}, dj_mag} * {{LEN_W{1'b0}}, dj_mag};
      dist_sum = DIST_W'(di2_ff) + DIST_W'(dj2);
      pix_hit = (j_c >= cmd_ff.col_lo) && (j_c < cmd_ff.col_hi) &&
                (dist_sum <= DIST_W'(cmd_ff.r2));
      for (int k = 0; k < MAX_COLS; k++) begin
         rect_mask[k] = (COL_CNT_W'(k) < cfg.eff_cols) &&
                        (coord_type'(COL_CNT_W'(k)) >= cmd_ff.col_lo) &&
                        (coord_type'(COL_CNT_W'(k)) < cmd_ff.col_hi);
      end
      row_mask = (cmd_ff.op == ACT_RECT) ? rect_mask : mask_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (cmd_ff.op)
               ACT_CLEAR: state_in = ST_IDLE;
               ACT_READ:  state_in = in_canvas ? ST_READ : ST_IDLE;
               default:   state_in = ST_ROW;
            endcase
         end
         ST_ROW: begin
            if (rows_done) begin
               state_in = ST_IDLE;
            end else if (row_hit) begin
               state_in = (cmd_ff.op == ACT_CIRCLE) ? ST_SCAN : ST_MERGE;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: state_in = ST_ROW;
         ST_READ:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cmd_in        = cmd_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      mask_in       = mask_ff;
      di2_in        = di2_ff;
      cmd_pop       = 1'b0;
      clear_all     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = row_idx;
      mem_wr_en     = 1'b0;
      mem_wr_data   = (rd_valid_ff ? rd_data_ff : '0) | row_mask;
      rsp_strobe_in = 1'b0;
      rsp_pixel_in  = PIXEL_OFF;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
            end
         end
         ST_DISPATCH: begin
            i_in = '0;
            unique case (cmd_ff.op)
               ACT_CLEAR: begin
                  clear_all     = 1'b1;
                  rsp_strobe_in = 1'b1;
               end
               ACT_READ: begin
                  mem_rd_en     = in_canvas;
                  mem_rd_addr   = cmd_ff.row_ctr[ROW_AW-1:0];
                  rsp_strobe_in = ~in_canvas;
               end
               default: ;
            endcase
         end
         ST_ROW: begin
            j_in    = '0;
            mask_in = '0;
            di2_in  = {{LEN_W{1'b0}}, di_mag} * {{LEN_W{1'b0}}, di_mag};
            if (rows_done) begin
               rsp_strobe_in = 1'b1;
            end else if (row_hit) begin
               mem_rd_en = 1'b1;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            mask_in[j_ff[COL_AW-1:0]] = pix_hit;
            j_in = j_ff + 1'b1;
         end
         ST_MERGE: begin
            mem_wr_en = 1'b1;
            i_in      = i_ff + 1'b1;
         end
         ST_READ: begin
            rsp_strobe_in = 1'b1;
            if (rd_valid_ff && rd_data_ff[cmd_ff.col_ctr[COL_AW-1:0]]) begin
               rsp_pixel_in = PIXEL_ON;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      mask_ff      <= mask_in;
      di2_ff       <= di2_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   // row valid bits: reset and clear drop every row at once
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         row_valid_ff <= '0;
      end else if (mem_wr_en) begin
         row_valid_ff[row_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         frame_mem[row_idx] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff  <= frame_mem[mem_rd_addr];
         rd_valid_ff <= row_valid_ff[mem_rd_addr];
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_pixel_value = rsp_pixel_ff;

`ifndef SYNTHESIS
   a_strobe_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("back-to-back result strobes");
   a_merge_in_canvas: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (i_ff < cfg.eff_rows))
      else $error("row write outside canvas");
   a_scan_in_canvas: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (j_ff < cfg.eff_cols))
      else $error("column scan outside canvas");
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE) && cmd_valid)
      else $error("command taken while busy");
`endif

endmodule

@@ design/shape_fill_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// shape_fill_rasterizer_unit
// Rectangle and circle fill rasterizer over a one-bit frame store.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/req_*; one is taken at each clock edge with start
//   high and busy low. busy rises only when the two-entry command queue is
//   full, so a second command can be handed over while the first runs.
//   Every command returns one transaction on rsp_strobe/rsp_pixel_value,
//   high for a single cycle; the receiver cannot stall it.
//   A command leaving the queue is dispatched: clear marks every store row
//   off; read fetches the store row and returns the pixel, or off without
//   a read for a pixel outside the canvas; rectangle and circle visit each
//   canvas row and, for rows inside the shape, read the row from the
//   single-port frame memory, merge the row mask and write it back, a
//   circle first building its mask with one distance test per cycle.
//   Canvas size is written on the APB-style port while no command is in
//   flight; the user must keep to this, as the block does not enforce it.
//   Reset returns the canvas to 64 x 64, empties the queue and marks every
//   store row off at once; the block is ready the next cycle.
// ----------------------------------------------------------------------------
module shape_fill_rasterizer_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [sfr_pkg::ACTION_W-1:0]          req_action,
   input  logic signed [sfr_pkg::COORD_IN_W-1:0] req_row,
   input  logic signed [sfr_pkg::COORD_IN_W-1:0] req_col,
   input  logic [sfr_pkg::LEN_W-1:0]             req_height,
   input  logic [sfr_pkg::LEN_W-1:0]             req_width,
   input  logic [sfr_pkg::LEN_W-1:0]             req_radius,
   output logic                                  rsp_strobe,
   output logic [sfr_pkg::PIXEL_W-1:0]           rsp_pixel_value,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [sfr_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import sfr_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   sfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_height (req_height),
      .req_width  (req_width),
      .req_radius (req_radius),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd)
   );

   sfr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd_valid       (cmd_valid),
      .cmd_pop         (cmd_pop),
      .cmd             (cmd),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel_value (rsp_pixel_value)
   );

endmodule
